@@ design/top_k_magnitude_selector_core_assert.svh @@
// Assertion macros used by the selector core's RTL.
// Each macro expects aclk and aresetn to be visible where it is used.
`ifndef TOP_K_MAGNITUDE_SELECTOR_CORE_ASSERT_SVH
`define TOP_K_MAGNITUDE_SELECTOR_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define TKMS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TKMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/tkms_pkg.sv @@
`default_nettype none

package tkms_pkg;

    // Field widths.
    localparam int ACT_W   = 16;
    localparam int MAG_W   = 15;
    localparam int POS_W   = 16;
    localparam int SEL_W   = 7;
    localparam int BATCH_W = 17;
    localparam int RATIO_W = 10;
    localparam int THR_W   = 15;

    // Stream and configuration port widths.
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 56;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 15;

    // Parameter defaults.
    localparam int MAX_SELECT_DEF = 64;
    localparam int MAX_COUNT_DEF  = 65536;

    // Register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_ENABLE    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RATIO     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_SEL   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_SEL   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_OUT_LIMIT = 3'd5;

    // Register reset values.
    localparam logic               ENABLE_RST    = 1'b0;
    localparam logic [RATIO_W-1:0] RATIO_RST     = 10'd154;
    localparam logic [SEL_W-1:0]   MIN_SEL_RST   = 7'd16;
    localparam logic [SEL_W-1:0]   MAX_SEL_RST   = 7'd64;
    localparam logic [THR_W-1:0]   THRESHOLD_RST = 15'd3277;
    localparam logic [SEL_W-1:0]   OUT_LIMIT_RST = 7'd64;

    // Limits applied to the ratio and maximum registers.
    localparam logic [RATIO_W-1:0] RATIO_LO = 10'd10;
    localparam logic [RATIO_W-1:0] RATIO_HI = 10'd512;
    localparam logic [SEL_W-1:0]   MAX_LO   = 7'd1;

    // The most negative activation and the saturated magnitude it maps to.
    localparam logic [MAG_W-1:0] MAG_SAT  = 15'h7FFF;
    localparam logic [ACT_W-1:0] ACT_MOST_NEG = 16'h8000;

    // Operation broadcast to every cell of the ranking chain.
    typedef enum logic [2:0] {
        OP_HOLD        = 3'd0,
        OP_INSERT      = 3'd1,
        OP_PROBE_LOAD  = 3'd2,
        OP_PROBE_SHIFT = 3'd3,
        OP_DRAIN       = 3'd4,
        OP_CLEAR       = 3'd5
    } cell_op_t;

    typedef struct packed {
        cell_op_t               op;
        logic [MAG_W-1:0]       mag;
        logic [POS_W-1:0]       pos;
        logic [THR_W-1:0]       thresh;
    } cell_cmd_t;

    // What one cell shows its neighbors.
    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic [POS_W-1:0] pos;
        logic             filled;
        logic             take;
        logic             probe;
    } cell_data_t;

endpackage

`default_nettype wire

@@ design/tkms_cell.sv @@
`default_nettype none

// One slot of the ranked list. On insert, a cell whose entry is beaten by
// the new magnitude (or that is empty) takes either the new entry or the
// entry of its left neighbor when that neighbor also moves. Drain and probe
// shifts move data one slot toward the head.
module tkms_cell (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire tkms_pkg::cell_cmd_t   cmd_i,
    input  wire tkms_pkg::cell_data_t  prev_i,
    input  wire tkms_pkg::cell_data_t  next_i,
    output tkms_pkg::cell_data_t       self_o
);

    logic [tkms_pkg::MAG_W-1:0] mag_reg, mag_next;
    logic [tkms_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                       filled_reg, filled_next;
    logic                       probe_reg, probe_next;
    logic                       take;

    // An empty slot or a smaller magnitude gives way; equal ones stay ahead.
    assign take = !filled_reg || (cmd_i.mag > mag_reg);

    assign self_o.mag    = mag_reg;
    assign self_o.pos    = pos_reg;
    assign self_o.filled = filled_reg;
    assign self_o.take   = take;
    assign self_o.probe  = probe_reg;

    // Next slot contents for the broadcast operation.
    always_comb begin
        mag_next    = mag_reg;
        pos_next    = pos_reg;
        filled_next = filled_reg;
        probe_next  = probe_reg;
        case (cmd_i.op)
            tkms_pkg::OP_INSERT: begin
                if (take) begin
                    if (prev_i.take) begin
                        mag_next    = prev_i.mag;
                        pos_next    = prev_i.pos;
                        filled_next = prev_i.filled;
                    end else begin
                        mag_next    = cmd_i.mag;
                        pos_next    = cmd_i.pos;
                        filled_next = 1'b1;
                    end
                end
            end
            tkms_pkg::OP_PROBE_LOAD: begin
                probe_next = filled_reg && (mag_reg >= cmd_i.thresh);
            end
            tkms_pkg::OP_PROBE_SHIFT: begin
                probe_next = next_i.probe;
            end
            tkms_pkg::OP_DRAIN: begin
                mag_next    = next_i.mag;
                pos_next    = next_i.pos;
                filled_next = next_i.filled;
            end
            tkms_pkg::OP_CLEAR: begin
                filled_next = 1'b0;
                probe_next  = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // Valid and probe bits are control state; the entry itself is payload.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filled_reg <= 1'b0;
            probe_reg  <= 1'b0;
        end else begin
            filled_reg <= filled_next;
            probe_reg  <= probe_next;
        end
        mag_reg <= mag_next;
        pos_reg <= pos_next;
    end

endmodule

`default_nettype wire

@@ design/top_k_magnitude_selector_core.sv @@
`default_nettype none

// Channel     | Port group      | Beat contents
// ------------+-----------------+-------------------------------------------
// input       | s_axis_*        | activation in tdata, is_final on tlast
// results     | m_axis_*        | index/magnitude/count/size in tdata,
//             |                 | none_selected in tuser, end_of_list tlast
// config      | cfg_*           | write of register cfg_addr, no read-back
//
// While a batch is open, one activation is accepted per cycle; the ranking
// chain of MAX_SELECT cells inserts each one (while fewer than MAX_COUNT
// have been counted) in the cycle it is accepted. After the final beat the
// block sizes the target (multiply and two clamp stages), scans the threshold
// flags down the chain, then emits one result beat per cycle unless stalled.
// Reset clears the chain valid bits, the item counter and the registers.
// A stall on the result side holds the output register and the chain.
module top_k_magnitude_selector_core #(
    parameter int MAX_SELECT = tkms_pkg::MAX_SELECT_DEF,
    parameter int MAX_COUNT  = tkms_pkg::MAX_COUNT_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    // tdata: activation[15:0]
    input  wire [tkms_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire                              s_axis_tlast,
    // tdata: neuron_index[15:0], magnitude[30:16], selected_count[37:31],
    //        batch_size[54:38], zero[55]
    output logic [tkms_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    output logic                             m_axis_tlast,
    // tuser: none_selected[0]
    output logic                             m_axis_tuser,
    input  wire                              cfg_we,
    input  wire [tkms_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire [tkms_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

`include "top_k_magnitude_selector_core_assert.svh"

    localparam int CNT_W   = $clog2(MAX_COUNT + 1);
    localparam int PROD_W  = CNT_W + tkms_pkg::RATIO_W;
    localparam int RAW_W   = CNT_W + 1;
    localparam int SEL_W   = tkms_pkg::SEL_W;
    localparam int SEL_CAP = (MAX_SELECT < 127) ? MAX_SELECT : 127;
    localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_COUNT);
    localparam logic [SEL_W-1:0] SEL_CAP_V = SEL_W'(SEL_CAP);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_MUL    = 6'b000010,
        ST_CLAMP1 = 6'b000100,
        ST_CLAMP2 = 6'b001000,
        ST_SCAN   = 6'b010000,
        ST_EMIT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic                             enable_reg;
    logic [tkms_pkg::RATIO_W-1:0]     ratio_reg;
    logic [SEL_W-1:0]                 min_sel_reg;
    logic [SEL_W-1:0]                 max_sel_reg;
    logic [tkms_pkg::THR_W-1:0]       thresh_reg;
    logic [SEL_W-1:0]                 out_limit_reg;

    // Batch and selection state.
    logic [CNT_W-1:0]                 cnt_reg, cnt_next;
    logic [tkms_pkg::RATIO_W-1:0]     ratio_use_reg, ratio_use_next;
    logic [SEL_W-1:0]                 minv_reg, minv_next;
    logic [SEL_W-1:0]                 maxv_reg, maxv_next;
    logic [PROD_W-1:0]                prod_reg, prod_next;
    logic [SEL_W-1:0]                 t1_reg, t1_next;
    logic [SEL_W-1:0]                 target_reg, target_next;
    logic [SEL_W-1:0]                 thcnt_reg, thcnt_next;
    logic [SEL_W-1:0]                 sel_reg, sel_next;
    logic [SEL_W-1:0]                 emit_reg, emit_next;

    // Output register.
    logic                             m_valid_reg, m_valid_next;
    logic [tkms_pkg::POS_W-1:0]       o_pos_reg, o_pos_next;
    logic [tkms_pkg::MAG_W-1:0]       o_mag_reg, o_mag_next;
    logic [SEL_W-1:0]                 o_sel_reg, o_sel_next;
    logic [tkms_pkg::BATCH_W-1:0]     o_batch_reg, o_batch_next;
    logic                             o_none_reg, o_none_next;
    logic                             o_last_reg, o_last_next;

    logic                             in_fire;
    logic                             counted;
    logic                             out_load;
    logic                             emit_last;
    logic [tkms_pkg::ACT_W-1:0]       act;
    logic [tkms_pkg::ACT_W-1:0]       act_neg;
    logic [tkms_pkg::MAG_W-1:0]       in_mag;
    logic [CNT_W+tkms_pkg::POS_W-1:0] cnt_pos_wide;
    logic [CNT_W+tkms_pkg::BATCH_W-1:0] cnt_batch_wide;
    logic [PROD_W:0]                  prod_round;
    logic [RAW_W-1:0]                 raw;
    tkms_pkg::cell_cmd_t              cmd;
    tkms_pkg::cell_data_t             cd [MAX_SELECT];
    tkms_pkg::cell_data_t             head;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign counted       = (cnt_reg < CNT_MAX);
    assign out_load      = (state_reg == ST_EMIT) && (!m_valid_reg || m_axis_tready);
    assign emit_last     = (sel_reg == '0) || (emit_reg == sel_reg - 7'd1);
    assign head          = cd[0];

    // Saturating magnitude of the incoming activation.
    assign act     = s_axis_tdata[tkms_pkg::ACT_W-1:0];
    assign act_neg = -act;
    always_comb begin
        if (act == tkms_pkg::ACT_MOST_NEG) begin
            in_mag = tkms_pkg::MAG_SAT;
        end else if (act[tkms_pkg::ACT_W-1]) begin
            in_mag = act_neg[tkms_pkg::MAG_W-1:0];
        end else begin
            in_mag = act[tkms_pkg::MAG_W-1:0];
        end
    end

    // Position and batch size carry the low bits of the counter.
    assign cnt_pos_wide   = (CNT_W + tkms_pkg::POS_W)'(cnt_reg);
    assign cnt_batch_wide = (CNT_W + tkms_pkg::BATCH_W)'(cnt_reg);

    // Rounded-up share of the count.
    assign prod_round = (PROD_W + 1)'(prod_reg) + (PROD_W + 1)'(1023);
    assign raw        = prod_round[PROD_W:tkms_pkg::RATIO_W];

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg    <= tkms_pkg::ENABLE_RST;
            ratio_reg     <= tkms_pkg::RATIO_RST;
            min_sel_reg   <= tkms_pkg::MIN_SEL_RST;
            max_sel_reg   <= tkms_pkg::MAX_SEL_RST;
            thresh_reg    <= tkms_pkg::THRESHOLD_RST;
            out_limit_reg <= tkms_pkg::OUT_LIMIT_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                tkms_pkg::REG_ENABLE:    enable_reg    <= cfg_wdata[0];
                tkms_pkg::REG_RATIO:     ratio_reg     <= cfg_wdata[tkms_pkg::RATIO_W-1:0];
                tkms_pkg::REG_MIN_SEL:   min_sel_reg   <= cfg_wdata[SEL_W-1:0];
                tkms_pkg::REG_MAX_SEL:   max_sel_reg   <= cfg_wdata[SEL_W-1:0];
                tkms_pkg::REG_THRESHOLD: thresh_reg    <= cfg_wdata[tkms_pkg::THR_W-1:0];
                tkms_pkg::REG_OUT_LIMIT: out_limit_reg <= cfg_wdata[SEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer: collect, size the target, scan the threshold flags, emit.
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ratio_use_next = ratio_use_reg;
        minv_next      = minv_reg;
        maxv_next      = maxv_reg;
        prod_next      = prod_reg;
        t1_next        = t1_reg;
        target_next    = target_reg;
        thcnt_next     = thcnt_reg;
        sel_next       = sel_reg;
        emit_next      = emit_reg;
        cmd.op         = tkms_pkg::OP_HOLD;
        cmd.mag        = in_mag;
        cmd.pos        = cnt_pos_wide[tkms_pkg::POS_W-1:0];
        cmd.thresh     = thresh_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (counted) begin
                        cmd.op   = tkms_pkg::OP_INSERT;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (s_axis_tlast) begin
                        // Snapshot the clamped limits for this batch.
                        if (ratio_reg < tkms_pkg::RATIO_LO) begin
                            ratio_use_next = tkms_pkg::RATIO_LO;
                        end else if (ratio_reg > tkms_pkg::RATIO_HI) begin
                            ratio_use_next = tkms_pkg::RATIO_HI;
                        end else begin
                            ratio_use_next = ratio_reg;
                        end
                        maxv_next  = (max_sel_reg < tkms_pkg::MAX_LO) ? tkms_pkg::MAX_LO
                                                                       : max_sel_reg;
                        minv_next  = (min_sel_reg > maxv_next) ? maxv_next : min_sel_reg;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                prod_next  = PROD_W'(cnt_reg) * PROD_W'(ratio_use_reg);
                state_next = ST_CLAMP1;
            end
            ST_CLAMP1: begin
                // Raise to the minimum, then lower to the maximum.
                if (raw < RAW_W'(minv_reg)) begin
                    t1_next = minv_reg;
                end else if (raw > RAW_W'(maxv_reg)) begin
                    t1_next = maxv_reg;
                end else begin
                    t1_next = raw[SEL_W-1:0];
                end
                state_next = ST_CLAMP2;
            end
            ST_CLAMP2: begin
                // Lower to the count, the output limit and the chain length.
                target_next = t1_reg;
                if (32'(target_next) > 32'(cnt_reg)) begin
                    target_next = SEL_W'(cnt_reg);
                end
                if (target_next > out_limit_reg) begin
                    target_next = out_limit_reg;
                end
                if (target_next > SEL_CAP_V) begin
                    target_next = SEL_CAP_V;
                end
                cmd.op     = tkms_pkg::OP_PROBE_LOAD;
                thcnt_next = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                // Threshold hits form a prefix; count them one per cycle.
                if (!enable_reg) begin
                    sel_next   = '0;
                    emit_next  = '0;
                    state_next = ST_EMIT;
                end else if (head.probe && (thcnt_reg < target_reg)) begin
                    cmd.op     = tkms_pkg::OP_PROBE_SHIFT;
                    thcnt_next = thcnt_reg + 1'b1;
                end else begin
                    if (minv_reg > target_reg) begin
                        sel_next = (thcnt_reg > target_reg) ? thcnt_reg : target_reg;
                    end else begin
                        sel_next = (thcnt_reg > minv_reg) ? thcnt_reg : minv_reg;
                    end
                    emit_next  = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_load) begin
                    if (emit_last) begin
                        cmd.op     = tkms_pkg::OP_CLEAR;
                        cnt_next   = '0;
                        state_next = ST_IDLE;
                    end else begin
                        cmd.op    = tkms_pkg::OP_DRAIN;
                        emit_next = emit_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: loads from the chain head while the result side moves.
    always_comb begin
        o_pos_next   = o_pos_reg;
        o_mag_next   = o_mag_reg;
        o_sel_next   = o_sel_reg;
        o_batch_next = o_batch_reg;
        o_none_next  = o_none_reg;
        o_last_next  = o_last_reg;
        m_valid_next = m_axis_tready ? 1'b0 : m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            o_batch_next = cnt_batch_wide[tkms_pkg::BATCH_W-1:0];
            o_last_next  = emit_last;
            o_sel_next   = sel_reg;
            if (sel_reg == '0) begin
                o_none_next = 1'b1;
                o_pos_next  = '0;
                o_mag_next  = '0;
            end else begin
                o_none_next = 1'b0;
                o_pos_next  = head.pos;
                o_mag_next  = head.mag;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        ratio_use_reg <= ratio_use_next;
        minv_reg      <= minv_next;
        maxv_reg      <= maxv_next;
        prod_reg      <= prod_next;
        t1_reg        <= t1_next;
        target_reg    <= target_next;
        thcnt_reg     <= thcnt_next;
        sel_reg       <= sel_next;
        emit_reg      <= emit_next;
        o_pos_reg     <= o_pos_next;
        o_mag_reg     <= o_mag_next;
        o_sel_reg     <= o_sel_next;
        o_batch_reg   <= o_batch_next;
        o_none_reg    <= o_none_next;
        o_last_reg    <= o_last_next;
    end

    // Ranking chain; the head cell feeds the output.
    for (genvar i = 0; i < MAX_SELECT; i++) begin : g_cell
        tkms_pkg::cell_data_t prev_d;
        tkms_pkg::cell_data_t next_d;
        if (i == 0) begin : g_first
            assign prev_d = '0;
        end else begin : g_inner_prev
            assign prev_d = cd[i-1];
        end
        if (i == MAX_SELECT - 1) begin : g_last
            assign next_d = '0;
        end else begin : g_inner_next
            assign next_d = cd[i+1];
        end
        tkms_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cmd_i   (cmd),
            .prev_i  (prev_d),
            .next_i  (next_d),
            .self_o  (cd[i])
        );
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tlast  = o_last_reg;
    assign m_axis_tuser  = o_none_reg;
    assign m_axis_tdata  = {1'b0, o_batch_reg, o_sel_reg, o_mag_reg, o_pos_reg};

    // The counter never runs past the batch limit.
    `TKMS_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_reg <= CNT_MAX, "item counter beyond limit")
    // The selection never exceeds the target while emitting.
    `TKMS_ASSERT_SAME(a_sel_bound, state_reg == ST_EMIT, sel_reg <= target_reg, "selection above target")
    // An empty result is the only beat of its batch and carries a zero count.
    `TKMS_ASSERT_SAME(a_none_beat, m_valid_reg && o_none_reg, o_last_reg && (o_sel_reg == '0), "bad empty result")
    // Loading the final beat closes the batch.
    `TKMS_ASSERT_NEXT(a_close, out_load && emit_last, (state_reg == ST_IDLE) && (cnt_reg == '0), "batch not closed")

endmodule

`default_nettype wire
